/* src/cbg_pkg.sv */
`default_nettype none
package cbg_pkg;

   localparam int unsigned FRAC_BITS    = 30;
   localparam int unsigned CORDIC_STEPS = 32;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [31:0] FIX_ONE = 32'sh4000_0000;

   // register indexes on the configuration port
   localparam logic [1:0] REG_NEGATE_POINTS = 2'd0;
   localparam logic [1:0] REG_POLY_ORDER    = 2'd1;
   localparam logic [1:0] REG_POINT_COUNT   = 2'd2;
   localparam logic [1:0] REG_USE_TRIG      = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_FOLD,
      ST_EMIT,
      ST_COSGO,
      ST_COSWAIT,
      ST_MUL,
      ST_ACC
   } seq_state_type;

   typedef enum logic [2:0] {
      COS_IDLE,
      COS_DIV,
      COS_PREP,
      COS_ROT,
      COS_DONE
   } cos_state_type;

   typedef struct packed {
      logic start;
   } cos_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cos_sts_type;

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic logic [31:0] cbg_atan(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h2000_0000;
         5'd1:  r = 32'h12E4_051E;
         5'd2:  r = 32'h09FB_385B;
         5'd3:  r = 32'h0511_11D4;
         5'd4:  r = 32'h028B_0D43;
         5'd5:  r = 32'h0145_D7E1;
         5'd6:  r = 32'h00A2_F61E;
         5'd7:  r = 32'h0051_7C55;
         5'd8:  r = 32'h0028_BE53;
         5'd9:  r = 32'h0014_5F2F;
         5'd10: r = 32'h000A_2F98;
         5'd11: r = 32'h0005_17CC;
         5'd12: r = 32'h0002_8BE6;
         5'd13: r = 32'h0001_45F3;
         5'd14: r = 32'h0000_A2FA;
         5'd15: r = 32'h0000_517D;
         5'd16: r = 32'h0000_28BE;
         5'd17: r = 32'h0000_145F;
         5'd18: r = 32'h0000_0A30;
         5'd19: r = 32'h0000_0518;
         5'd20: r = 32'h0000_028C;
         5'd21: r = 32'h0000_0146;
         5'd22: r = 32'h0000_00A3;
         5'd23: r = 32'h0000_0051;
         5'd24: r = 32'h0000_0029;
         5'd25: r = 32'h0000_0014;
         5'd26: r = 32'h0000_000A;
         5'd27: r = 32'h0000_0005;
         5'd28: r = 32'h0000_0003;
         5'd29: r = 32'h0000_0001;
         5'd30: r = 32'h0000_0001;
         default: r = 32'h0000_0000;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -40'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* src/cbg_if.sv */
`default_nettype none
interface cbg_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] sample_index;
   modport source (output valid, output sample_index, input ready);
   modport sink (input valid, input sample_index, output ready);
endinterface

interface cbg_rsp_if;
   logic               valid;
   logic               ready;
   logic [5:0]         degree;
   logic signed [31:0] poly_value;
   logic               last_degree;
   modport source (output valid, output degree, output poly_value, output last_degree,
                   input ready);
   modport sink (input valid, input degree, input poly_value, input last_degree,
                 output ready);
endinterface
`default_nettype wire

/* src/chebyshev_basis_generator.sv */
`default_nettype none
// Chebyshev basis generator: for each accepted sample index i it emits T_0..T_N
// at tau = s*cos(pi*i/M) as signed Q2.30 values, lowest degree first, with the last
// one flagged. One sample at a time: the input is not ready until the last result
// of the sample is loaded into the output register. A cosine is computed in the
// shared unit (restoring divider, prep, 32 CORDIC rotations, done) after a start
// state. In recursive mode a sample goes through accept, reduction of the index
// modulo 2M, fold and the degree-zero output, a cosine for degree one, then one
// multiply, one add and one output step per further degree; in trig mode each degree
// above zero takes its own cosine, the cosine unit setting the pace. A stalled output
// holds the sequencer. Registers are at byte offsets 0, 4, 8 and 12.
module chebyshev_basis_generator
   import cbg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   cbg_req_if.sink          req_chan,
   cbg_rsp_if.source        rsp_chan,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic        negate_ff;
   logic [5:0]  order_ff;
   logic [11:0] count_ff;
   logic        trig_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         negate_ff <= 1'b0;
         order_ff  <= '0;
         count_ff  <= 12'd1;
         trig_ff   <= 1'b0;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_NEGATE_POINTS: negate_ff <= csr_pwdata[0];
            REG_POLY_ORDER:    order_ff  <= csr_pwdata[5:0];
            REG_POINT_COUNT:   count_ff  <= csr_pwdata[11:0];
            REG_USE_TRIG:      trig_ff   <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_NEGATE_POINTS: csr_prdata = {31'd0, negate_ff};
         REG_POLY_ORDER:    csr_prdata = {26'd0, order_ff};
         REG_POINT_COUNT:   csr_prdata = {20'd0, count_ff};
         REG_USE_TRIG:      csr_prdata = {31'd0, trig_ff};
         default:           csr_prdata = '0;
      endcase
   end

   logic [11:0] m_eff;
   logic [12:0] m2;
   assign m_eff = (count_ff == 12'd0) ? 12'd1 : count_ff;
   assign m2    = {m_eff, 1'b0};

   seq_state_type state_ff, state_in;
   logic [11:0]        idx_ff, idx_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [12:0]        rem_ff, rem_in;
   logic [12:0]        k_ff, k_in;
   logic [12:0]        a_ff, a_in;
   logic [5:0]         j_ff, j_in;
   logic signed [31:0] tau_ff, tau_in, t0_ff, t0_in, t1_ff, t1_in, cand_ff, cand_in;
   logic signed [63:0] prod_ff, prod_in;
   logic               ovalid_ff, ovalid_in;
   logic [5:0]         odeg_ff, odeg_in;
   logic signed [31:0] oval_ff, oval_in;
   logic               olast_ff, olast_in;

   logic               accept, out_free;
   logic [13:0]        shifted, fold_sum, a_sum;
   logic [12:0]        fold_k;
   logic signed [64:0] rounded;
   logic signed [39:0] acc_val;

   cos_ctl_type        cos_ctl;
   cos_sts_type        cos_sts;
   logic signed [31:0] cos_value;

   cbg_cos u_cos (
      .clock     (clock),
      .reset     (reset),
      .ctl       (cos_ctl),
      .angle     (a_ff),
      .m_val     (m_eff),
      .m2_val    (m2),
      .sts       (cos_sts),
      .cos_value (cos_value)
   );

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !ovalid_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (accept) state_in = ST_MOD;
         ST_MOD:     if (cnt_ff == 4'd11) state_in = ST_FOLD;
         ST_FOLD:    state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               if (j_ff == order_ff) state_in = ST_IDLE;
               else if (trig_ff || j_ff == 6'd0) state_in = ST_COSGO;
               else state_in = ST_MUL;
            end
         end
         ST_COSGO:   state_in = ST_COSWAIT;
         ST_COSWAIT: if (cos_sts.done) state_in = ST_EMIT;
         ST_MUL:     state_in = ST_ACC;
         ST_ACC:     state_in = ST_EMIT;
         default:    state_in = ST_IDLE;
      endcase
   end

   assign shifted  = {rem_ff, idx_ff[4'd11 - cnt_ff]};
   assign fold_sum = {2'b0, m_eff} + {1'b0, m2} - {1'b0, rem_ff};
   assign fold_k   = (fold_sum >= {1'b0, m2}) ? 13'(fold_sum - {1'b0, m2}) : fold_sum[12:0];
   assign a_sum    = {1'b0, a_ff} + {1'b0, k_ff};
   assign rounded  = 65'(prod_ff) + (65'sd1 <<< (FRAC_BITS - 2));
   assign acc_val  = 40'(rounded >>> (FRAC_BITS - 1)) - 40'(t0_ff);

   always_comb begin
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      k_in      = k_ff;
      a_in      = a_ff;
      j_in      = j_ff;
      tau_in    = tau_ff;
      t0_in     = t0_ff;
      t1_in     = t1_ff;
      cand_in   = cand_ff;
      prod_in   = prod_ff;
      ovalid_in = ovalid_ff && !rsp_chan.ready;
      odeg_in   = odeg_ff;
      oval_in   = oval_ff;
      olast_in  = olast_ff;
      cos_ctl.start   = 1'b0;
      req_chan.ready  = state_ff == ST_IDLE;
      case (state_ff)
         ST_IDLE: begin
            idx_in = req_chan.sample_index;
            cnt_in = '0;
            rem_in = '0;
         end
         ST_MOD: begin
            // i mod 2M, one bit a cycle
            rem_in = (shifted >= {1'b0, m2}) ? 13'(shifted - {1'b0, m2}) : shifted[12:0];
            cnt_in = cnt_ff + 4'd1;
         end
         ST_FOLD: begin
            k_in    = negate_ff ? fold_k : rem_ff;
            a_in    = negate_ff ? fold_k : rem_ff;
            j_in    = '0;
            cand_in = FIX_ONE;
         end
         ST_EMIT: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               odeg_in   = j_ff;
               oval_in   = cand_ff;
               olast_in  = j_ff == order_ff;
               t0_in     = t1_ff;
               t1_in     = cand_ff;
               j_in      = j_ff + 6'd1;
               // next angle j*k mod 2M
               if (j_ff != 6'd0) begin
                  a_in = (a_sum >= {1'b0, m2}) ? 13'(a_sum - {1'b0, m2}) : a_sum[12:0];
               end
            end
         end
         ST_COSGO: begin
            cos_ctl.start = 1'b1;
         end
         ST_COSWAIT: begin
            if (cos_sts.done) begin
               cand_in = cos_value;
               if (j_ff == 6'd1) tau_in = cos_value;
            end
         end
         ST_MUL: begin
            prod_in = tau_ff * t1_ff;
         end
         ST_ACC: begin
            cand_in = sat32(acc_val);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
      end
      idx_ff   <= idx_in;
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      k_ff     <= k_in;
      a_ff     <= a_in;
      j_ff     <= j_in;
      tau_ff   <= tau_in;
      t0_ff    <= t0_in;
      t1_ff    <= t1_in;
      cand_ff  <= cand_in;
      prod_ff  <= prod_in;
      odeg_ff  <= odeg_in;
      oval_ff  <= oval_in;
      olast_ff <= olast_in;
   end

   assign rsp_chan.valid       = ovalid_ff;
   assign rsp_chan.degree      = odeg_ff;
   assign rsp_chan.poly_value  = oval_ff;
   assign rsp_chan.last_degree = olast_ff;

   a_last_matches_order: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.last_degree == (rsp_chan.degree == order_ff)))
      else $error("last flag disagrees with degree");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_chan.ready)
      else $error("input ready right after a transaction");

   a_cos_start_idle: assert property (@(posedge clock) disable iff (reset)
      cos_ctl.start |-> !cos_sts.busy)
      else $error("cosine unit started while busy");

   a_degree_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.degree <= order_ff)
      else $error("degree beyond order");

endmodule
`default_nettype wire

/* src/cbg_cos.sv */
`default_nettype none
module cbg_cos
   import cbg_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cos_ctl_type        ctl,
   input  wire logic [12:0]        angle,
   input  wire logic [11:0]        m_val,
   input  wire logic [12:0]        m2_val,
   output cos_sts_type             sts,
   output logic signed [31:0]      cos_value
);

   cos_state_type state_ff, state_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [12:0]        rem_ff, rem_in;
   logic [31:0]        q_ff, q_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [32:0] z_ff, z_in;
   logic               neg_ff, neg_in;

   logic [31:0]        m_word;
   logic [13:0]        shifted;
   logic               qbit;
   logic signed [32:0] ph;
   logic signed [33:0] dx, dy;
   logic signed [32:0] at;
   logic signed [34:0] xs;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         COS_IDLE: if (ctl.start) state_in = COS_DIV;
         COS_DIV:  if (cnt_ff == 5'd31) state_in = COS_PREP;
         COS_PREP: state_in = COS_ROT;
         COS_ROT:  if (cnt_ff == 5'd31) state_in = COS_DONE;
         COS_DONE: state_in = COS_IDLE;
         default:  state_in = COS_IDLE;
      endcase
   end

   assign m_word  = {20'd0, m_val};
   assign shifted = {rem_ff, m_word[5'd31 - cnt_ff]};
   assign qbit    = shifted >= {1'b0, m2_val};
   assign ph      = {q_ff[31], q_ff};
   assign dx      = y_ff >>> cnt_ff;
   assign dy      = x_ff >>> cnt_ff;
   assign at      = {1'b0, cbg_atan(cnt_ff)};

   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      q_in   = q_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      z_in   = z_ff;
      neg_in = neg_ff;
      case (state_ff)
         COS_IDLE: begin
            cnt_in = '0;
            rem_in = angle;
            q_in   = '0;
         end
         COS_DIV: begin
            // restoring division of angle*2^32 + m by 2m, one quotient bit a cycle
            rem_in = qbit ? 13'(shifted - {1'b0, m2_val}) : shifted[12:0];
            q_in   = {q_ff[30:0], qbit};
            cnt_in = cnt_ff + 5'd1;
         end
         COS_PREP: begin
            // fold into the right half plane
            if (ph > 33'sh0_4000_0000) begin
               z_in   = ph - 33'sh0_8000_0000;
               neg_in = 1'b1;
            end else if (ph < -33'sh0_4000_0000) begin
               z_in   = ph + 33'sh0_8000_0000;
               neg_in = 1'b1;
            end else begin
               z_in   = ph;
               neg_in = 1'b0;
            end
            x_in   = CORDIC_GAIN;
            y_in   = '0;
            cnt_in = '0;
         end
         COS_ROT: begin
            if (!z_ff[32]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + at;
            end
            cnt_in = cnt_ff + 5'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= COS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
   end

   assign xs = neg_ff ? -35'(x_ff) : 35'(x_ff);

   always_comb begin
      sts.busy  = state_ff != COS_IDLE;
      sts.done  = state_ff == COS_DONE;
      cos_value = sat32(40'(xs));
   end

endmodule
`default_nettype wire
